>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on a clock with an active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> rtl/core/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg
// types and constants of the midi to cv/gate router
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcg_pkg;

  localparam int unsigned GATE_SR_COUNT_DEF = 8;
  localparam int unsigned MAP_W             = 64;
  localparam int unsigned MAX_RES           = 3;
  localparam int unsigned CV_SHIFT          = 9;

  localparam logic [7:0] PORT_ANALOG = 8'h80;
  localparam logic [7:0] PORT_SYNC   = 8'hff;
  localparam logic [7:0] STATUS_SYNC = 8'hf9;

  localparam logic [3:0] EV_NOTE_OFF = 4'h8;
  localparam logic [3:0] EV_NOTE_ON  = 4'h9;
  localparam logic [3:0] EV_CC       = 4'hb;

  localparam logic [3:0] CHN_GATE_SR = 4'd15;
  localparam logic [3:0] CHN_NOTE_LAST = 4'd7;
  localparam logic [3:0] CHN_PAIR_LAST = 4'd11;

  localparam logic [6:0] GATE_NOTE_BASE = 7'h24;
  localparam logic [6:0] CC_CV_BASE     = 7'd16;

  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_CV   = 3'd1;
  localparam logic [2:0] ACT_GATE = 3'd2;
  localparam logic [2:0] ACT_DOUT = 3'd3;
  localparam logic [2:0] ACT_SYNC = 3'd4;

  typedef struct packed {
    logic [7:0] port;
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
  } in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [10:0] target;
    logic [15:0] level;
    logic        filtered;
    logic        last;
  } out_t;

  // all results of one message, unused slots zero
  typedef struct packed {
    out_t [MAX_RES-1:0] res;
  } bundle_t;

endpackage

`default_nettype wire

>>> rtl/core/midi_to_cv_gate_router_unit.sv
// ----------------------------------------------------------------------------
// midi_to_cv_gate_router_unit
// routes outgoing midi messages to cv, gate, dout and sync actions
// ----------------------------------------------------------------------------
// first result: the message is held in the input register, then loaded into the
//   result register, from which its first result is offered
// results: 1..3 per message, handed out by the result register one result per
//   cycle while out_stall_i is low; the next message loads as the last leaves
// reset: map register clears to zero, input and result registers empty
`timescale 1ns / 1ps
`default_nettype none

module midi_to_cv_gate_router_unit #(
  parameter int unsigned GATE_SR_COUNT = mcg_pkg::GATE_SR_COUNT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [mcg_pkg::MAP_W-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  mcg_pkg::in_t            in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output mcg_pkg::out_t           out_data_o
);

  logic [GATE_SR_COUNT*8-1:0] map_q;
  mcg_pkg::in_t               in_q;
  logic                       in_vld_q;
  logic                       seq_ready;
  logic                       load;
  mcg_pkg::bundle_t           bundle;

  assign load       = in_vld_q && seq_ready;
  assign in_stall_o = in_vld_q && !seq_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
    end else if (cfg_we_i) begin
      map_q <= cfg_wdata_i[GATE_SR_COUNT*8-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (load) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  mcg_decode #(
    .GATE_SR_COUNT(GATE_SR_COUNT)
  ) u_decode (
    .msg_i    (in_q),
    .map_i    (map_q),
    .bundle_o (bundle)
  );

  mcg_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bundle_i    (bundle),
    .ready_o     (seq_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/mcg_decode.sv
// ----------------------------------------------------------------------------
// mcg_decode
// turns one registered message into its list of cv, gate, dout and sync actions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcg_decode #(
  parameter int unsigned GATE_SR_COUNT = mcg_pkg::GATE_SR_COUNT_DEF
) (
  input  mcg_pkg::in_t                 msg_i,
  input  logic [GATE_SR_COUNT*8-1:0]   map_i,
  output mcg_pkg::bundle_t             bundle_o
);

  always_comb begin
    logic [3:0]  ev;
    logic [3:0]  chn;
    logic [6:0]  d2;
    logic [6:0]  gp;
    logic [3:0]  sr;
    logic [7:0]  entry;
    logic [7:0]  entry_m1;
    logic [2:0]  note_ch;
    logic [2:0]  vel_ch;
    logic [2:0]  gate;
    logic        has_vel;
    logic [6:0]  cc_ch;
    logic        cc_ok;
    logic        filt;
    logic [1:0]  n;

    bundle_o = '0;
    ev       = msg_i.status_byte[7:4];
    chn      = msg_i.status_byte[3:0];
    d2       = msg_i.data_two;
    gp       = msg_i.data_one - mcg_pkg::GATE_NOTE_BASE;
    sr       = {1'b0, gp[6:4]} << 1 | {3'b0, gp[3]};
    entry    = '0;
    entry_m1 = '0;
    note_ch  = '0;
    vel_ch   = '0;
    gate     = '0;
    has_vel  = 1'b0;
    cc_ch    = '0;
    cc_ok    = 1'b0;
    filt     = 1'b0;
    n        = 2'd1;

    for (int g = 0; g < GATE_SR_COUNT; g++) begin
      if (sr == 4'(g)) begin
        entry = map_i[g*8 +: 8];
      end
    end
    entry_m1 = entry - 8'd1;

    if (chn <= mcg_pkg::CHN_NOTE_LAST) begin
      note_ch = chn[2:0];
      gate    = chn[2:0];
    end else if (chn <= mcg_pkg::CHN_PAIR_LAST) begin
      note_ch = {chn[1:0], 1'b0};
      vel_ch  = {chn[1:0], 1'b1};
      has_vel = 1'b1;
      gate    = {1'b0, chn[1:0]};
    end else begin
      vel_ch  = {chn[1:0], 1'b0};
      note_ch = {chn[1:0], 1'b1};
      has_vel = 1'b1;
      gate    = {1'b0, chn[1:0]};
    end

    if (chn <= mcg_pkg::CHN_NOTE_LAST) begin
      cc_ok = msg_i.data_one >= mcg_pkg::CC_CV_BASE;
      cc_ch = msg_i.data_one - mcg_pkg::CC_CV_BASE;
    end else begin
      cc_ok = 1'b1;
      cc_ch = {4'b0, chn[2:0]};
    end

    // note off behaves as note on with zero velocity
    if (ev == mcg_pkg::EV_NOTE_OFF) begin
      ev = mcg_pkg::EV_NOTE_ON;
      d2 = '0;
    end

    if (msg_i.port == mcg_pkg::PORT_SYNC && msg_i.status_byte == mcg_pkg::STATUS_SYNC) begin
      filt                  = 1'b1;
      bundle_o.res[0].action = mcg_pkg::ACT_SYNC;
    end else if (msg_i.port == mcg_pkg::PORT_ANALOG) begin
      filt = 1'b1;
      if (ev == mcg_pkg::EV_NOTE_ON) begin
        if (chn == mcg_pkg::CHN_GATE_SR) begin
          // shift-register gate pins, group picked by note above the base
          if (msg_i.data_one >= mcg_pkg::GATE_NOTE_BASE &&
              32'(sr) < GATE_SR_COUNT && entry != 8'd0) begin
            bundle_o.res[0].action = mcg_pkg::ACT_DOUT;
            bundle_o.res[0].target = {entry_m1, gp[2:0]};
            bundle_o.res[0].level  = {15'b0, d2 != 7'd0};
          end
        end else if (d2 != 7'd0) begin
          bundle_o.res[0].action = mcg_pkg::ACT_CV;
          bundle_o.res[0].target = {8'b0, note_ch};
          bundle_o.res[0].level  = {msg_i.data_one, 9'b0};
          if (has_vel) begin
            bundle_o.res[1].action = mcg_pkg::ACT_CV;
            bundle_o.res[1].target = {8'b0, vel_ch};
            bundle_o.res[1].level  = {d2, 9'b0};
            bundle_o.res[2].action = mcg_pkg::ACT_GATE;
            bundle_o.res[2].target = {8'b0, gate};
            bundle_o.res[2].level  = 16'd1;
            n = 2'd3;
          end else begin
            bundle_o.res[1].action = mcg_pkg::ACT_GATE;
            bundle_o.res[1].target = {8'b0, gate};
            bundle_o.res[1].level  = 16'd1;
            n = 2'd2;
          end
        end else begin
          bundle_o.res[0].action = mcg_pkg::ACT_GATE;
          bundle_o.res[0].target = {8'b0, gate};
          bundle_o.res[0].level  = 16'd0;
        end
      end else if (ev == mcg_pkg::EV_CC && cc_ok) begin
        bundle_o.res[0].action = mcg_pkg::ACT_CV;
        bundle_o.res[0].target = {4'b0, cc_ch};
        bundle_o.res[0].level  = {msg_i.data_two, 9'b0};
        bundle_o.res[1].action = mcg_pkg::ACT_GATE;
        bundle_o.res[1].target = {4'b0, cc_ch};
        bundle_o.res[1].level  = 16'd1;
        n = 2'd2;
      end
    end

    for (int i = 0; i < mcg_pkg::MAX_RES; i++) begin
      if (2'(i) == n - 2'd1) begin
        bundle_o.res[i].last     = 1'b1;
        bundle_o.res[i].filtered = filt;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mcg_seq.sv
// ----------------------------------------------------------------------------
// mcg_seq
// result register: holds one message's results and hands them out in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mcg_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  mcg_pkg::bundle_t bundle_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mcg_pkg::out_t    out_data_o
);

  mcg_pkg::bundle_t bundle_q;
  logic [1:0]       idx_q;
  logic [1:0]       idx_d;
  logic             busy_q;
  logic             busy_d;
  logic             xfer;
  mcg_pkg::out_t    cur;

  assign cur         = bundle_q.res[idx_q];
  assign xfer        = busy_q && !out_stall_i;
  assign ready_o     = !busy_q || (xfer && cur.last);
  assign out_valid_o = busy_q;
  assign out_data_o  = cur;

  always_comb begin
    idx_d  = idx_q;
    busy_d = busy_q;
    if (load_i) begin
      idx_d  = '0;
      busy_d = 1'b1;
    end else if (xfer) begin
      if (cur.last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

  // a new message only replaces one whose last result is leaving
  `ASSERT_CLK(a_load_on_last, clk_i, rst_ni, load_i && busy_q |-> !out_stall_i && cur.last)
  `ASSERT_CLK(a_load_restarts, clk_i, rst_ni, load_i |=> busy_q && idx_q == 2'd0)
  `ASSERT_CLK(a_more_follow, clk_i, rst_ni, xfer && !cur.last && !load_i |=> busy_q)
  `ASSERT_NEVER(a_past_last, clk_i, rst_ni,
                busy_q && idx_q != 2'd0 && bundle_q.res[idx_q - 2'd1].last)

endmodule

`default_nettype wire
